FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the string-to-integer parser.
// No dependencies; take in with `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/spu_pkg.sv
// Types and constants of the string-to-integer parser.
// No dependencies; imported by spu_step and string_to_integer_parser_unit.
package spu_pkg;

  localparam int unsigned MAX_LENGTH = 65535;
  localparam logic [15:0] COUNT_CAP  =
    (MAX_LENGTH < 65535) ? 16'(MAX_LENGTH) : 16'hFFFF;

  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] BASE_BAD   = 6'd1;
  localparam logic [5:0] BASE_MIN   = 6'd2;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_MAX   = 6'd36;
  localparam logic [5:0] NOT_DIGIT  = 6'd36;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    PH_WS     = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_HEXPFX = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        negative;
    logic [5:0]  active_base;
    logic [63:0] acc;
    logic        overflowed;
    logic        any_digit;
    logic [15:0] char_count;
    logic [15:0] zero_prefix_offset;
  } parse_state_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               overflow;
    logic               digits_found;
    logic [15:0]        end_offset;
  } parse_result_t;

  localparam parse_state_t CLEAR_STATE = '{
    phase: PH_WS, negative: 1'b0, active_base: BASE_AUTO, acc: 64'd0,
    overflowed: 1'b0, any_digit: 1'b0, char_count: 16'd0,
    zero_prefix_offset: 16'd0
  };

endpackage

FILE: hw/rtl/spu_step.sv
// One character step of the parser: next parse state and the result word.
// Depends on spu_pkg for the state, result and phase types.
module spu_step import spu_pkg::*; (
  input  parse_state_t  cur,
  input  logic [5:0]    number_base,
  input  logic          start_new,
  input  logic [7:0]    char_code,
  output parse_state_t  nxt,
  output logic          emit,
  output parse_result_t res
);

  parse_state_t s;
  logic         done;
  logic [15:0]  pos;
  logic [5:0]   d;
  logic         is_space;
  logic [69:0]  wide;
  logic [63:0]  limit;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= "0" && c <= "9") begin
      t = c - 8'("0");
    end else if (c >= "a" && c <= "z") begin
      t = c - 8'("a") + 8'd10;
    end else if (c >= "A" && c <= "Z") begin
      t = c - 8'("A") + 8'd10;
    end else begin
      t = 8'(NOT_DIGIT);
    end
    return t[5:0];
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v < COUNT_CAP) ? v + 16'd1 : COUNT_CAP;
  endfunction

  assign d        = digit_of(char_code);
  assign is_space = (char_code == " ") || (char_code >= 8'h09 && char_code <= 8'h0D);

  always_comb begin
    s     = start_new ? CLEAR_STATE : cur;
    pos   = s.char_count;
    done  = (s.phase >= PH_DONE);
    emit  = 1'b0;
    res   = '0;
    wide  = '0;
    limit = POS_LIMIT;

    if (!done && s.phase == PH_WS) begin
      if (is_space) begin
        s.char_count = sat_inc(s.char_count);
        done = 1'b1;
      end else begin
        s.phase = PH_SIGN;
        if (char_code == "-" || char_code == "+") begin
          s.negative   = (char_code == "-");
          s.char_count = sat_inc(s.char_count);
          done = 1'b1;
        end
      end
    end

    if (!done && s.phase == PH_SIGN) begin
      if (number_base == BASE_AUTO) begin
        s.active_base = BASE_AUTO;
      end else if (number_base >= BASE_MIN && number_base <= BASE_MAX) begin
        s.active_base = number_base;
      end else begin
        s.active_base = BASE_BAD;
      end
      if (char_code == "0" && (s.active_base == BASE_AUTO || s.active_base == BASE_HEX)) begin
        s.any_digit          = 1'b1;
        s.acc                = 64'd0;
        s.zero_prefix_offset = sat_inc(pos);
        s.phase              = PH_ZERO;
        s.char_count         = sat_inc(s.char_count);
        done = 1'b1;
      end else begin
        if (s.active_base == BASE_AUTO) s.active_base = BASE_DEC;
        s.phase = PH_DIGITS;
      end
    end

    if (!done && s.phase == PH_ZERO) begin
      if (char_code == "x" || char_code == "X") begin
        s.active_base = BASE_HEX;
        s.phase       = PH_HEXPFX;
        s.char_count  = sat_inc(s.char_count);
        done = 1'b1;
      end else begin
        if (s.active_base == BASE_AUTO) s.active_base = BASE_OCT;
        s.phase = PH_DIGITS;
      end
    end

    if (!done && s.phase == PH_HEXPFX) begin
      if (d < BASE_HEX) begin
        s.phase = PH_DIGITS;
      end else begin
        // bare 0x: the number is the 0, the end sits just past it
        s.acc              = 64'd0;
        s.overflowed       = 1'b0;
        s.any_digit        = 1'b1;
        s.phase            = PH_DONE;
        emit               = 1'b1;
        res.value          = 64'sd0;
        res.overflow       = 1'b0;
        res.digits_found   = 1'b1;
        res.end_offset     = s.zero_prefix_offset;
        done = 1'b1;
      end
    end

    if (!done) begin
      if (s.active_base >= BASE_MIN && d < s.active_base) begin
        // overflow when acc * base + d passes the limit for the sign
        limit = s.negative ? NEG_LIMIT : POS_LIMIT;
        wide  = 70'(s.acc) * 70'(s.active_base) + 70'(d);
        if (!s.overflowed) begin
          if (wide > 70'(limit)) begin
            s.overflowed = 1'b1;
          end else begin
            s.acc = wide[63:0];
          end
        end
        s.any_digit  = 1'b1;
        s.char_count = sat_inc(s.char_count);
      end else begin
        emit    = 1'b1;
        s.phase = PH_DONE;
        if (!s.any_digit) begin
          res.value = 64'sd0;
        end else if (s.overflowed) begin
          res.value = s.negative ? $signed(NEG_LIMIT) : $signed(POS_LIMIT);
        end else begin
          res.value = s.negative ? $signed(64'd0 - s.acc) : $signed(s.acc);
        end
        res.overflow     = s.overflowed;
        res.digits_found = s.any_digit;
        res.end_offset   = s.any_digit ? pos : 16'd0;
      end
    end

    nxt = s;
  end

endmodule

FILE: hw/rtl/string_to_integer_parser_unit.sv
// Top level of the string-to-integer parser: input register, parse state,
// result register and the radix register. Uses spu_pkg and spu_step.
//
// Takes one character word per cycle, unless a held result stalls it, and gives
// one result word per number after the character that ends it is accepted (it
// sits in the input register, then the result register loads). The sustained
// rate is one character per cycle when not stalled; it is set by the parse state
// loop, which does one 64-by-6-bit multiply-add and the signed limit compare.
// A result waiting in the result register holds the next character in the
// input register but a new one is still taken while the input register
// drains. Write number_base only while no string is in flight.
`include "assert_macros.svh"

module string_to_integer_parser_unit import spu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [5:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               start_new,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] value,
  output logic               overflow,
  output logic               digits_found,
  output logic [15:0]        end_offset
);

  logic [5:0]    number_base;
  logic          stage_valid;
  logic          stage_start;
  logic [7:0]    stage_char;
  parse_state_t  state;
  parse_state_t  state_next;
  logic          step_emit;
  parse_result_t step_res;
  parse_result_t out_res;
  logic          advance;

  spu_step u_step (
    .cur         (state),
    .number_base (number_base),
    .start_new   (stage_start),
    .char_code   (stage_char),
    .nxt         (state_next),
    .emit        (step_emit),
    .res         (step_res)
  );

  // advance the input word when the result register is free or draining
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_AUTO;
    end else if (cfg_we) begin
      number_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_start <= start_new;
      stage_char  <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR_STATE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      out_res <= step_res;
    end
  end

  assign value        = out_res.value;
  assign overflow     = out_res.overflow;
  assign digits_found = out_res.digits_found;
  assign end_offset   = out_res.end_offset;

  `ASSERT_NEXT(a_done_after_emit, advance && step_emit, state.phase == PH_DONE, "phase not done")
  `ASSERT_IMPLIES(a_result_from_stage, $rose(out_valid), $past(stage_valid), "result without word")
  `ASSERT_IMPLIES(a_no_digit_zero, out_valid && !digits_found,
    value == 64'sd0 && !overflow && end_offset == 16'd0, "no-digit result not zero")
  `ASSERT_IMPLIES(a_overflow_sat, out_valid && overflow,
    value == $signed(POS_LIMIT) || value == $signed(NEG_LIMIT), "overflow value not saturated")

endmodule

FILE: sim/string_to_integer_parser_unit_test.sv
`timescale 1ns / 1ps
// Testbench for string_to_integer_parser_unit: drives character words, predicts each
// parse result in step with the block and checks every result word. Uses spu_pkg.
module string_to_integer_parser_unit_test import spu_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_wdata = 6'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic start_new = 1'b0;
  logic [7:0] char_code = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] value;
  logic overflow;
  logic digits_found;
  logic [15:0] end_offset;

  string_to_integer_parser_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .start_new(start_new),
    .char_code(char_code), .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .overflow(overflow), .digits_found(digits_found),
    .end_offset(end_offset)
  );

  always #6 clk = ~clk;

  int cycle_count = 0;
  int error_count = 0;
  int chars_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_left = 0;
  logic [5:0] radix_setting = BASE_AUTO;

  parse_result_t pending_results[$];

  // Shadow of the parse state
  phase_t      p_phase;
  logic        p_neg;
  logic [5:0]  p_base;
  logic [63:0] p_acc;
  logic        p_ovf;
  logic        p_any;
  logic [15:0] p_count;
  logic [15:0] p_zoff;
  logic [5:0]  p_radix_reg;

  function automatic logic [15:0] bump_count(input logic [15:0] v);
    return (v < COUNT_CAP) ? v + 16'd1 : COUNT_CAP;
  endfunction

  function automatic logic [5:0] digit_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 6'(c - "0");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 10);
    if (c >= "A" && c <= "Z") return 6'(c - "A" + 10);
    return NOT_DIGIT;
  endfunction

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    if (d < 6'd10) return 8'("0" + d);
    if ($urandom_range(1)) return 8'("a" + d - 10);
    return 8'("A" + d - 10);
  endfunction

  function automatic logic [7:0] ws_char();
    int k;
    k = $urandom_range(6);
    return (k >= 5) ? 8'd32 : 8'(9 + k);
  endfunction

  task automatic clear_parser();
    p_phase = PH_WS;
    p_neg = 1'b0;
    p_base = BASE_AUTO;
    p_acc = 64'd0;
    p_ovf = 1'b0;
    p_any = 1'b0;
    p_count = 16'd0;
    p_zoff = 16'd0;
  endtask

  task automatic finish_number(input logic [15:0] end_pos);
    parse_result_t r;
    if (!p_any) r.value = 64'sd0;
    else if (p_ovf) r.value = p_neg ? NEG_LIMIT : POS_LIMIT;
    else r.value = p_neg ? (64'd0 - p_acc) : p_acc;
    r.overflow = p_ovf;
    r.digits_found = p_any;
    r.end_offset = end_pos;
    pending_results.push_back(r);
    p_phase = PH_DONE;
  endtask

  task automatic advance_parser(input logic sn, input logic [7:0] c);
    logic [15:0] pos;
    logic [5:0] d;
    logic [63:0] lim;
    if (sn) clear_parser();
    if (p_phase >= PH_DONE) return;
    pos = p_count;
    if (p_phase == PH_WS) begin
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
        p_count = bump_count(p_count);
        return;
      end
      p_phase = PH_SIGN;
      if (c == "-" || c == "+") begin
        p_neg = (c == "-");
        p_count = bump_count(p_count);
        return;
      end
    end
    if (p_phase == PH_SIGN) begin
      if (p_radix_reg == BASE_AUTO) p_base = BASE_AUTO;
      else if (p_radix_reg >= BASE_MIN && p_radix_reg <= BASE_MAX) p_base = p_radix_reg;
      else p_base = BASE_BAD;
      if (c == "0" && (p_base == BASE_AUTO || p_base == BASE_HEX)) begin
        p_any = 1'b1;
        p_acc = 64'd0;
        p_zoff = bump_count(pos);
        p_phase = PH_ZERO;
        p_count = bump_count(p_count);
        return;
      end
      if (p_base == BASE_AUTO) p_base = BASE_DEC;
      p_phase = PH_DIGITS;
    end
    if (p_phase == PH_ZERO) begin
      if (c == "x" || c == "X") begin
        p_base = BASE_HEX;
        p_phase = PH_HEXPFX;
        p_count = bump_count(p_count);
        return;
      end
      if (p_base == BASE_AUTO) p_base = BASE_OCT;
      p_phase = PH_DIGITS;
    end
    if (p_phase == PH_HEXPFX) begin
      if (digit_val(c) < BASE_HEX) begin
        p_phase = PH_DIGITS;
      end else begin
        // bare prefix: the number ends just past the zero
        p_acc = 64'd0;
        p_ovf = 1'b0;
        p_any = 1'b1;
        finish_number(p_zoff);
        return;
      end
    end
    d = digit_val(c);
    if (p_base >= BASE_MIN && d < p_base) begin
      if (!p_ovf) begin
        lim = p_neg ? NEG_LIMIT : POS_LIMIT;
        if (p_acc > (lim - {58'd0, d}) / {58'd0, p_base}) p_ovf = 1'b1;
        else p_acc = p_acc * {58'd0, p_base} + {58'd0, d};
      end
      p_any = 1'b1;
      p_count = bump_count(p_count);
      return;
    end
    finish_number(p_any ? pos : 16'd0);
  endtask

  // Track config writes and accepted characters
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      p_radix_reg = BASE_AUTO;
    end else begin
      if (cfg_we) p_radix_reg = cfg_wdata;
      if (in_valid && in_ready) advance_parser(start_new, char_code);
    end
  end

  always @(posedge clk) begin
    parse_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected: value %0d", $realtime, value);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (value !== exp_r.value) begin
          $display("%0t: value expected %0d actual %0d", $realtime, exp_r.value, value);
          error_count++;
        end
        if (overflow !== exp_r.overflow) begin
          $display("%0t: overflow expected %0d actual %0d", $realtime, exp_r.overflow,
                   overflow);
          error_count++;
        end
        if (digits_found !== exp_r.digits_found) begin
          $display("%0t: digits_found expected %0d actual %0d", $realtime,
                   exp_r.digits_found, digits_found);
          error_count++;
        end
        if (end_offset !== exp_r.end_offset) begin
          $display("%0t: end_offset expected %0d actual %0d", $realtime, exp_r.end_offset,
                   end_offset);
          error_count++;
        end
      end
    end
  end

  // Receiver: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** string_to_integer_parser_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_char(input logic sn, input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    start_new <= sn;
    char_code <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic fresh, input logic [7:0] term);
    logic first;
    first = fresh;
    for (int i = 0; i < s.len(); i++) begin
      send_char(first, s[i]);
      first = 1'b0;
    end
    send_char(first, term);
  endtask

  // Drop valid and let the last word drain through both registers
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_base(input logic [5:0] b);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_we <= 1'b0;
    radix_setting = b;
  endtask

  function automatic logic [5:0] pick_base();
    case ($urandom_range(11))
      0, 1, 2: return BASE_AUTO;
      3: return BASE_DEC;
      4: return BASE_HEX;
      5: return BASE_OCT;
      6: return BASE_MIN;
      7: return BASE_MAX;
      8: return BASE_BAD;
      9: return 6'($urandom_range(63, 37));
      10: return 6'($urandom_range(36, 2));
      default: return 6'($urandom_range(63));
    endcase
  endfunction

  task automatic send_random_number();
    int n_ws, n_dig, n_tail, k;
    logic [5:0] dig_base;
    logic fresh;
    logic [7:0] c;
    fresh = 1'b1;
    n_ws = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
    repeat (n_ws) begin
      send_char(fresh, ws_char());
      fresh = 1'b0;
    end
    k = $urandom_range(3);
    if (k == 0) begin
      send_char(fresh, "-");
      fresh = 1'b0;
    end else if (k == 1) begin
      send_char(fresh, "+");
      fresh = 1'b0;
    end
    dig_base = radix_setting;
    if (radix_setting == BASE_AUTO || radix_setting == BASE_HEX) begin
      k = $urandom_range(5);
      if (k <= 1) begin
        send_char(fresh, "0");
        send_char(1'b0, k ? "x" : "X");
        fresh = 1'b0;
        dig_base = BASE_HEX;
      end else if (k == 2 && radix_setting == BASE_AUTO) begin
        send_char(fresh, "0");
        fresh = 1'b0;
        dig_base = BASE_OCT;
      end else if (radix_setting == BASE_AUTO) begin
        dig_base = BASE_DEC;
      end
    end else if (radix_setting < BASE_MIN || radix_setting > BASE_MAX) begin
      dig_base = BASE_MAX;
    end
    k = $urandom_range(99);
    if (k < 5) n_dig = 0;
    else if (k < 80) n_dig = $urandom_range(6, 1);
    else if (k < 95) n_dig = $urandom_range(22, 14);
    else n_dig = $urandom_range(70, 55);
    repeat (n_dig) begin
      send_char(fresh, digit_char(6'($urandom_range(dig_base - 1))));
      fresh = 1'b0;
    end
    case ($urandom_range(5))
      0: c = 8'd0;
      1: c = " ";
      2: c = ";";
      3: c = "-";
      default: c = 8'($urandom_range(255));
    endcase
    send_char(fresh, c);
    n_tail = $urandom_range(2);
    repeat (n_tail) send_char(1'b0, 8'($urandom_range(255)));
  endtask

  task automatic send_noise();
    int n;
    logic [7:0] c;
    n = $urandom_range(8, 1);
    repeat (n) begin
      case ($urandom_range(9))
        0: c = "0";
        1: c = "x";
        2: c = "+";
        3: c = "-";
        4: c = ws_char();
        default: c = 8'($urandom_range(255));
      endcase
      send_char($urandom_range(3) == 0, c);
    end
  endtask

  task automatic test_auto_radix_forms();
    send_idle_pct = 0;
    stall_pct = 0;
    // first string comes without start_new after reset
    send_text(" -123", 1'b0, 8'd0);
    send_text("0x1F", 1'b1, ";");
    send_text("0x", 1'b1, ";");
    send_text("0755", 1'b1, " ");
    send_text("9223372036854775807", 1'b1, 8'd0);
    send_text("9223372036854775808", 1'b1, 8'd0);
    send_text("-9223372036854775808", 1'b1, 8'd255);
    send_text("-9223372036854775809", 1'b1, 8'd0);
    send_text("+-5", 1'b1, 8'd0);
    send_text("abc", 1'b1, 8'd0);
    // every whitespace code, then the neighbors that are not whitespace
    send_char(1'b1, 8'd9);
    send_char(1'b0, 8'd10);
    send_char(1'b0, 8'd11);
    send_char(1'b0, 8'd12);
    send_char(1'b0, 8'd13);
    send_text(" 42", 1'b0, 8'd14);
    send_char(1'b1, 8'd8);
    // trailing characters after the result are dropped
    send_text("5", 1'b1, " ");
    send_text("78", 1'b0, 8'd0);
    send_text("0", 1'b1, 8'd0);
    send_text("09", 1'b1, 8'd0);
  endtask

  task automatic test_fixed_radix();
    set_base(BASE_MIN);
    send_text("1011", 1'b1, "2");
    send_text("1111111111111111111111111111111111111111111111111111111111111111", 1'b1,
              8'd0);
    set_base(BASE_MAX);
    send_text("-zZ9", 1'b1, "!");
    send_text("1y2kbzzzzzzzzz", 1'b1, 8'd0);
    set_base(BASE_HEX);
    send_text("0X1aG", 1'b1, 8'd0);
    send_text("0x", 1'b1, ";");
    send_text("-ff", 1'b1, 8'd0);
    set_base(BASE_OCT);
    send_text("0779", 1'b1, 8'd0);
    set_base(BASE_DEC);
    send_text("007", 1'b1, ";");
    set_base(BASE_BAD);
    send_text("1", 1'b1, ";");
    set_base(6'd37);
    send_text("12", 1'b1, ";");
    set_base(6'd63);
    send_text("7", 1'b1, ";");
  endtask

  task automatic test_long_string();
    set_base(BASE_AUTO);
    // long run of whitespace before the sign and digits
    send_char(1'b1, " ");
    repeat (150) send_char(1'b0, " ");
    send_text("+42", 1'b0, 8'd0);
  endtask

  task automatic test_result_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    set_base(BASE_DEC);
    @(posedge clk);
    hold_off_left = 300;
    for (int i = 0; i < 20; i++) send_text($sformatf("%0d", i), 1'b1, ";");
  endtask

  task automatic test_random_strings(input int n_chars, input int s_pct, input int r_pct);
    int target;
    send_idle_pct = s_pct;
    stall_pct = r_pct;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      if ($urandom_range(9) == 0) set_base(pick_base());
      if ($urandom_range(99) < 80) send_random_number();
      else send_noise();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_auto_radix_forms();
    test_fixed_radix();
    test_long_string();
    test_result_backpressure();
    test_random_strings(250, 0, 0);
    test_random_strings(250, 55, 0);
    test_random_strings(250, 0, 55);
    test_random_strings(250, 32, 32);
    set_base(BASE_AUTO);
    wait_drained();
    if (error_count == 0) begin
      $display("** string_to_integer_parser_unit: PASSED **");
    end else begin
      $display("** string_to_integer_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/spu_pkg.sv
hw/rtl/spu_step.sv
hw/rtl/string_to_integer_parser_unit.sv
sim/string_to_integer_parser_unit_test.sv
